// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the integrator core, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define BBI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BBI_ASSERT(lbl, clk, rstn, prop, msg)
`define BBI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/bbi_pkg.sv =====
// ----------------------------------------------------------------------------
// bbi_pkg
// Item types, configuration view and constants of the bouncing body integrator
// ----------------------------------------------------------------------------
package bbi_pkg;

    // unsigned Q16 factors (dt, restitution, friction coefficient)
    localparam int unsigned Q_SHIFT = 16;
    localparam int unsigned QW      = 17;
    localparam logic [QW-1:0] QONE  = 17'h10000;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_EPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_THR    = 3'd4;

    // register reset values
    localparam logic [30:0] DEF_GRAVITY     = 31'd41943040;
    localparam logic [16:0] DEF_RESTITUTION = 17'd32768;
    localparam logic [16:0] DEF_FRICTION    = 17'd0;
    localparam logic [15:0] DEF_VEL_EPS     = 16'd66;
    localparam logic [31:0] DEF_IDLE_THR    = 32'd6000;

    typedef struct packed {
        logic              mode;
        logic [31:0]       now_ms;
        logic [15:0]       step_dt;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_pos_z;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
        logic signed [31:0] load_vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic              landed;
        logic              idle;
    } out_item_t;

    // settings as the datapath uses them, factors already clamped
    typedef struct packed {
        logic [30:0]   gravity;
        logic [QW-1:0] rest_q;
        logic [QW-1:0] fric_coef;
        logic [15:0]   vel_eps;
        logic [31:0]   idle_thr;
    } cfg_t;

endpackage

// ===== sv/bouncing_body_integrator_core.sv =====
// ----------------------------------------------------------------------------
// bouncing_body_integrator_core
// One body's position and velocity, stepped by semi-implicit Euler with bounce
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_item take one item: a load (mode 1) or a step (mode 0).
//   m_valid/m_ready/m_item return exactly one result item per input item.
//   cfg_wr_en/cfg_index/cfg_wdata write the settings; write only while idle.
// timing
//   load or resting body: ST_IDLE, then ST_DONE, which registers the result.
//   step: ST_GRAV, ST_PX, ST_PY, ST_PZ, ST_ZC, ST_EPS, ST_DONE; a step that
//   reaches the ground runs ST_RV, ST_RP, ST_FX and ST_FY before ST_EPS.
//   every product goes through the one shared multiplier, one per cycle,
//   and some use an earlier result. s_ready is high only while no item is
//   in work, so one item at a time: a new item waits until ST_DONE has ended.
// reset
//   aresetn low clears position, velocity and last-moved time to zero and
//   restores the default settings; no item is pending afterwards.
// stall
//   a result held by m_ready low waits in the output register; the next item
//   is accepted meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module bouncing_body_integrator_core #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bbi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bbi_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bbi_pkg::out_item_t              m_item
);

    localparam int unsigned AW = ((COORD_WIDTH > 31) ? COORD_WIDTH : 31) + 1;

    bbi_pkg::cfg_t              cfg;
    logic signed [AW-1:0]       mul_a;
    logic [bbi_pkg::QW-1:0]     mul_b;
    logic signed [AW+1:0]       mul_q;

    bbi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bbi_mul #(
        .OPA_WIDTH (AW)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .q    (mul_q)
    );

    bbi_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_q   (mul_q)
    );

endmodule

// ===== sv/bbi_cfg.sv =====
// ----------------------------------------------------------------------------
// bbi_cfg
// Configuration registers with clamped restitution and friction coefficient
// ----------------------------------------------------------------------------
module bbi_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bbi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_wdata,
    output bbi_pkg::cfg_t                       cfg
);

    logic [30:0]              gravity_reg;
    logic [bbi_pkg::QW-1:0]   restitution_reg;
    logic [bbi_pkg::QW-1:0]   friction_reg;
    logic [15:0]              vel_eps_reg;
    logic [31:0]              idle_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg     <= bbi_pkg::DEF_GRAVITY;
            restitution_reg <= bbi_pkg::DEF_RESTITUTION;
            friction_reg    <= bbi_pkg::DEF_FRICTION;
            vel_eps_reg     <= bbi_pkg::DEF_VEL_EPS;
            idle_thr_reg    <= bbi_pkg::DEF_IDLE_THR;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bbi_pkg::REG_GRAVITY:     gravity_reg     <= cfg_wdata[30:0];
                bbi_pkg::REG_RESTITUTION: restitution_reg <= cfg_wdata[bbi_pkg::QW-1:0];
                bbi_pkg::REG_FRICTION:    friction_reg    <= cfg_wdata[bbi_pkg::QW-1:0];
                bbi_pkg::REG_VEL_EPS:     vel_eps_reg     <= cfg_wdata[15:0];
                bbi_pkg::REG_IDLE_THR:    idle_thr_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // factors above one act as one
    always_comb begin
        cfg.gravity   = gravity_reg;
        cfg.rest_q    = (restitution_reg > bbi_pkg::QONE) ? bbi_pkg::QONE : restitution_reg;
        cfg.fric_coef = bbi_pkg::QONE -
                        ((friction_reg > bbi_pkg::QONE) ? bbi_pkg::QONE : friction_reg);
        cfg.vel_eps   = vel_eps_reg;
        cfg.idle_thr  = idle_thr_reg;
    end

endmodule

// ===== sv/bbi_mul.sv =====
// ----------------------------------------------------------------------------
// bbi_mul
// Shared signed multiplier by an unsigned Q16 factor, registered, floor shift
// ----------------------------------------------------------------------------
module bbi_mul #(
    parameter int unsigned OPA_WIDTH = 33
) (
    input  logic                          aclk,
    input  logic signed [OPA_WIDTH-1:0]   op_a,
    input  logic [bbi_pkg::QW-1:0]        op_b,
    output logic signed [OPA_WIDTH+1:0]   q
);

    localparam int unsigned PW = OPA_WIDTH + bbi_pkg::QW + 1;

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * $signed({1'b0, op_b});
    end

    // dropping the low bits of a two's complement product rounds toward minus infinity
    assign q = prod_reg[PW-1:bbi_pkg::Q_SHIFT];

endmodule

// ===== sv/bbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbi_ctrl
// Sequencer and body state: drives the shared multiplier one product a step
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbi_ctrl #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bbi_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bbi_pkg::in_item_t                   s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bbi_pkg::out_item_t                  m_item,
    output logic signed [((COORD_WIDTH > 31) ? COORD_WIDTH : 31):0] mul_a,
    output logic [bbi_pkg::QW-1:0]              mul_b,
    input  logic signed [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)+2:0] mul_q
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned AW = ((CW > 31) ? CW : 31) + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GRAV, ST_PX, ST_PY, ST_PZ, ST_ZC,
        ST_RV, ST_RP, ST_FX, ST_FY, ST_EPS, ST_DONE
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       pos_x_reg, pos_y_reg, pos_z_reg;
    logic [CW-1:0]       vel_x_reg, vel_y_reg, vel_z_reg;
    logic [CW-1:0]       prev_x_reg, prev_y_reg, prev_z_reg;
    logic [31:0]         last_reg;
    logic                mode_reg;
    logic [31:0]         now_reg;
    logic [15:0]         dt_reg;
    logic                m_valid_reg;
    bbi_pkg::out_item_t  m_item_reg;

    logic [CW-1:0]       prod_lo;
    logic [CW-1:0]       pz_sum;
    logic                ground;
    logic                at_rest;
    logic                moved;
    logic                idle_cmp;
    logic                landed;
    logic [31:0]         idle_diff;

    function automatic logic signed [AW-1:0] sext_a(input logic [CW-1:0] v);
        return {{(AW-CW){v[CW-1]}}, v};
    endfunction

    // low 32 bits of the state word, zero padded when the word is narrower
    function automatic logic [31:0] to_out(input logic [CW-1:0] v);
        logic [CW+31:0] w;
        w = (CW+32)'(v);
        return w[31:0];
    endfunction

    function automatic logic [CW-1:0] from_in(input logic [31:0] v);
        logic [CW+31:0] w;
        w = {{CW{v[31]}}, v};
        return w[CW-1:0];
    endfunction

    function automatic logic is_small(input logic [CW-1:0] v, input logic [15:0] eps);
        logic [CW:0] w;
        logic [CW:0] mag;
        w   = {v[CW-1], v};
        mag = v[CW-1] ? (~w + 1'b1) : w;
        return mag < (CW+1)'(eps);
    endfunction

    assign prod_lo   = mul_q[CW-1:0];
    assign pz_sum    = pos_z_reg + prod_lo;
    assign ground    = pz_sum[CW-1] || (pz_sum == '0);
    assign at_rest   = (vel_x_reg == '0) && (vel_y_reg == '0) && (vel_z_reg == '0) &&
                       (pos_z_reg == '0);
    assign moved     = (pos_x_reg != prev_x_reg) || (pos_y_reg != prev_y_reg) ||
                       (pos_z_reg != prev_z_reg);
    assign idle_diff = now_reg - last_reg;
    assign idle_cmp  = idle_diff > cfg.idle_thr;
    assign landed    = !mode_reg && !prev_z_reg[CW-1] && (prev_z_reg != '0) &&
                       (pos_z_reg == '0);

    // operands for the product that is issued in this state
    always_comb begin
        unique case (state_reg)
            ST_GRAV: begin
                mul_a = $signed(AW'(cfg.gravity));
                mul_b = {1'b0, dt_reg};
            end
            ST_PX: begin
                mul_a = sext_a(vel_x_reg);
                mul_b = {1'b0, dt_reg};
            end
            ST_PY: begin
                mul_a = sext_a(vel_y_reg);
                mul_b = {1'b0, dt_reg};
            end
            ST_PZ: begin
                mul_a = sext_a(vel_z_reg);
                mul_b = {1'b0, dt_reg};
            end
            ST_ZC: begin
                mul_a = sext_a(vel_z_reg);
                mul_b = cfg.rest_q;
            end
            ST_RV: begin
                mul_a = sext_a(pos_z_reg);
                mul_b = cfg.rest_q;
            end
            ST_RP: begin
                mul_a = sext_a(vel_x_reg);
                mul_b = cfg.fric_coef;
            end
            ST_FX: begin
                mul_a = sext_a(vel_y_reg);
                mul_b = cfg.fric_coef;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            vel_z_reg   <= '0;
            last_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_item.mode;
                        now_reg    <= s_item.now_ms;
                        dt_reg     <= s_item.step_dt;
                        prev_x_reg <= pos_x_reg;
                        prev_y_reg <= pos_y_reg;
                        prev_z_reg <= pos_z_reg;
                        if (s_item.mode) begin
                            pos_x_reg <= from_in(s_item.load_pos_x);
                            pos_y_reg <= from_in(s_item.load_pos_y);
                            pos_z_reg <= from_in(s_item.load_pos_z);
                            vel_x_reg <= from_in(s_item.load_vel_x);
                            vel_y_reg <= from_in(s_item.load_vel_y);
                            vel_z_reg <= from_in(s_item.load_vel_z);
                            last_reg  <= s_item.now_ms;
                            state_reg <= ST_DONE;
                        end else if (at_rest) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_GRAV;
                        end
                    end
                end
                ST_GRAV: state_reg <= ST_PX;
                ST_PX: begin
                    vel_z_reg <= vel_z_reg - prod_lo;
                    state_reg <= ST_PY;
                end
                ST_PY: begin
                    pos_x_reg <= pos_x_reg + prod_lo;
                    state_reg <= ST_PZ;
                end
                ST_PZ: begin
                    pos_y_reg <= pos_y_reg + prod_lo;
                    state_reg <= ST_ZC;
                end
                ST_ZC: begin
                    pos_z_reg <= pz_sum;
                    state_reg <= ground ? ST_RV : ST_EPS;
                end
                // bounce: z terms flip sign and scale by restitution, x and y lose the friction share
                ST_RV: begin
                    vel_z_reg <= '0 - prod_lo;
                    state_reg <= ST_RP;
                end
                ST_RP: begin
                    pos_z_reg <= '0 - prod_lo;
                    state_reg <= ST_FX;
                end
                ST_FX: begin
                    vel_x_reg <= prod_lo;
                    state_reg <= ST_FY;
                end
                ST_FY: begin
                    vel_y_reg <= prod_lo;
                    state_reg <= ST_EPS;
                end
                ST_EPS: begin
                    if (is_small(vel_x_reg, cfg.vel_eps)) vel_x_reg <= '0;
                    if (is_small(vel_y_reg, cfg.vel_eps)) vel_y_reg <= '0;
                    if (is_small(vel_z_reg, cfg.vel_eps)) vel_z_reg <= '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg.pos_x  <= to_out(pos_x_reg);
                        m_item_reg.pos_y  <= to_out(pos_y_reg);
                        m_item_reg.pos_z  <= to_out(pos_z_reg);
                        m_item_reg.vel_x  <= to_out(vel_x_reg);
                        m_item_reg.vel_y  <= to_out(vel_y_reg);
                        m_item_reg.vel_z  <= to_out(vel_z_reg);
                        m_item_reg.landed <= landed;
                        // a move resets the idle timer, so only an unmoved body can be idle
                        m_item_reg.idle   <= !mode_reg && !moved && idle_cmp;
                        m_valid_reg       <= 1'b1;
                        if (!mode_reg && moved) begin
                            last_reg <= now_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `BBI_ASSERT(a_landed_at_ground, aclk, aresetn,
        m_valid_reg && m_item_reg.landed |-> m_item_reg.pos_z == '0,
        "landed reported with nonzero height")
    `BBI_ASSERT(a_landed_not_idle, aclk, aresetn,
        m_valid_reg |-> !(m_item_reg.landed && m_item_reg.idle),
        "landed and idle reported together")
    `BBI_ASSERT(a_zc_branch, aclk, aresetn,
        state_reg == ST_ZC |=> state_reg == ST_RV || state_reg == ST_EPS,
        "height check left to an unexpected step")
    `BBI_ASSERT(a_result_from_done, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE),
        "result raised outside the finishing step")

endmodule

// ===== dv/bouncing_body_integrator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bouncing_body_integrator_core_tb
// Drives load and step items into the integrator and checks every result
// against a cycle-free model of the body (gravity, Euler step, bounce with
// restitution and friction, velocity cutoff, landed and idle flags). Runs a
// short directed list, then bounce runs and noise under several settings
// with random stalls on both channels in all phases but the last two.
// ----------------------------------------------------------------------------
module bouncing_body_integrator_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_PX = 32'h0001_0000;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [bbi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    bbi_pkg::in_item_t             s_item;
    logic                          m_valid;
    logic                          m_ready;
    bbi_pkg::out_item_t            m_item;

    bouncing_body_integrator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // body model state and settings
    logic signed [31:0] body_pos [3];
    logic signed [31:0] body_vel [3];
    logic [31:0]        moved_ms;
    logic [30:0]        set_gravity;
    logic [16:0]        set_rest;
    logic [16:0]        set_fric;
    logic [15:0]        set_eps;
    logic [31:0]        set_idle_thr;

    bbi_pkg::in_item_t  body_cmds [$];
    bbi_pkg::out_item_t predicted_reports [$];
    int        cmds_queued = 0;
    int        cmds_taken = 0;
    int        reports_seen = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 16;
    int        recv_idle_pct = 77;
    logic      item_taken = 1'b0;
    logic [31:0] sim_ms = 32'd0;

    // value times unsigned Q16 factor (at most 1.0), floor shift
    function automatic logic signed [31:0] scale_q16(logic signed [31:0] v, logic [16:0] f);
        longint p;
        p = longint'(v) * longint'(f);
        return p[47:16];
    endfunction

    function automatic bbi_pkg::out_item_t step_body(bbi_pkg::in_item_t it);
        bbi_pkg::out_item_t r;
        logic signed [31:0] was [3];
        logic [16:0]        rq;
        logic [16:0]        fq;
        longint             gp;
        longint             mag;
        logic [31:0]        gdt;
        int                 i;
        r = '0;
        if (it.mode) begin
            body_pos[0] = it.load_pos_x;
            body_pos[1] = it.load_pos_y;
            body_pos[2] = it.load_pos_z;
            body_vel[0] = it.load_vel_x;
            body_vel[1] = it.load_vel_y;
            body_vel[2] = it.load_vel_z;
            moved_ms = it.now_ms;
        end else begin
            if (!(body_vel[0] == 0 && body_vel[1] == 0 && body_vel[2] == 0 &&
                  body_pos[2] == 0)) begin
                for (i = 0; i < 3; i++) was[i] = body_pos[i];
                rq = (set_rest > bbi_pkg::QONE) ? bbi_pkg::QONE : set_rest;
                fq = bbi_pkg::QONE - ((set_fric > bbi_pkg::QONE) ? bbi_pkg::QONE : set_fric);
                gp = longint'(set_gravity) * longint'(it.step_dt);
                gdt = gp[47:16];
                body_vel[2] = body_vel[2] - gdt;
                for (i = 0; i < 3; i++)
                    body_pos[i] = body_pos[i] + scale_q16(body_vel[i], {1'b0, it.step_dt});
                if (body_pos[2] <= 0) begin
                    body_vel[2] = -scale_q16(body_vel[2], rq);
                    body_pos[2] = -scale_q16(body_pos[2], rq);
                    body_vel[0] = scale_q16(body_vel[0], fq);
                    body_vel[1] = scale_q16(body_vel[1], fq);
                end
                for (i = 0; i < 3; i++) begin
                    mag = (body_vel[i] < 0) ? -longint'(body_vel[i]) : longint'(body_vel[i]);
                    if (mag < longint'(set_eps)) body_vel[i] = '0;
                end
                if (body_pos[0] != was[0] || body_pos[1] != was[1] || body_pos[2] != was[2])
                    moved_ms = it.now_ms;
                r.landed = (was[2] > 0) && (body_pos[2] == 0);
            end
            // unsigned difference, wraps with the ms counter
            r.idle = (it.now_ms - moved_ms) > set_idle_thr;
        end
        r.pos_x = body_pos[0];
        r.pos_y = body_pos[1];
        r.pos_z = body_pos[2];
        r.vel_x = body_vel[0];
        r.vel_y = body_vel[1];
        r.vel_z = body_vel[2];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d, %s: expected %h, got %h",
                     reports_seen, what, want, got);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || item_taken) begin
                if (body_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item <= body_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge aclk) begin
        item_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    flag_mismatch("result with none pending", 32'd0, m_item.pos_x);
                end else begin
                    bbi_pkg::out_item_t want;
                    want = predicted_reports.pop_front();
                    if (m_item.pos_x !== want.pos_x) flag_mismatch("pos_x", want.pos_x, m_item.pos_x);
                    if (m_item.pos_y !== want.pos_y) flag_mismatch("pos_y", want.pos_y, m_item.pos_y);
                    if (m_item.pos_z !== want.pos_z) flag_mismatch("pos_z", want.pos_z, m_item.pos_z);
                    if (m_item.vel_x !== want.vel_x) flag_mismatch("vel_x", want.vel_x, m_item.vel_x);
                    if (m_item.vel_y !== want.vel_y) flag_mismatch("vel_y", want.vel_y, m_item.vel_y);
                    if (m_item.vel_z !== want.vel_z) flag_mismatch("vel_z", want.vel_z, m_item.vel_z);
                    if (m_item.landed !== want.landed)
                        flag_mismatch("landed", {31'd0, want.landed}, {31'd0, m_item.landed});
                    if (m_item.idle !== want.idle)
                        flag_mismatch("idle", {31'd0, want.idle}, {31'd0, m_item.idle});
                end
                reports_seen++;
            end
            if (s_valid && s_ready) begin
                predicted_reports.push_back(step_body(s_item));
                cmds_taken++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic bbi_pkg::in_item_t random_cmd();
        bbi_pkg::in_item_t c;
        c.mode = 1'($urandom_range(1));
        c.now_ms = $urandom;
        c.step_dt = 16'($urandom);
        c.load_pos_x = $urandom;
        c.load_pos_y = $urandom;
        c.load_pos_z = $urandom;
        c.load_vel_x = $urandom;
        c.load_vel_y = $urandom;
        c.load_vel_z = $urandom;
        return c;
    endfunction

    task automatic queue_cmd(input bbi_pkg::in_item_t c);
        body_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_load(input logic [31:0] now, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] vz);
        bbi_pkg::in_item_t c;
        c = random_cmd();
        c.mode = 1'b1;
        c.now_ms = now;
        c.load_pos_x = px;
        c.load_pos_y = py;
        c.load_pos_z = pz;
        c.load_vel_x = vx;
        c.load_vel_y = vy;
        c.load_vel_z = vz;
        queue_cmd(c);
    endtask

    task automatic queue_step(input logic [31:0] now, input logic [15:0] dt);
        bbi_pkg::in_item_t c;
        c = random_cmd();
        c.mode = 1'b0;
        c.now_ms = now;
        c.step_dt = dt;
        queue_cmd(c);
    endtask

    // a body thrown from some height, then a run of frame steps
    task automatic queue_drop(input int steps);
        logic [31:0] pz;
        logic [31:0] vz;
        logic [15:0] dt;
        int          k;
        pz = $urandom_range(0, 30000000);
        vz = $urandom_range(0, 60000000) - 30000000;
        if ($urandom_range(7) == 0) begin
            pz = '0;
            vz = '0;
        end
        queue_load(sim_ms, $urandom_range(0, 40000000) - 20000000,
                   $urandom_range(0, 40000000) - 20000000, pz,
                   $urandom_range(0, 40000000) - 20000000,
                   $urandom_range(0, 40000000) - 20000000, vz);
        dt = 16'($urandom_range(1000, 8000));
        for (k = 0; k < steps; k++) begin
            if ($urandom_range(19) == 0)
                sim_ms += $urandom_range(100, 9000);
            else
                sim_ms += ((dt * 1000) >> 16) + $urandom_range(0, 3);
            queue_step(sim_ms, ($urandom_range(15) == 0) ? 16'd0 : dt);
        end
    endtask

    task automatic write_reg(input logic [bbi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            bbi_pkg::REG_GRAVITY:     set_gravity = val[30:0];
            bbi_pkg::REG_RESTITUTION: set_rest = val[16:0];
            bbi_pkg::REG_FRICTION:    set_fric = val[16:0];
            bbi_pkg::REG_VEL_EPS:     set_eps = val[15:0];
            bbi_pkg::REG_IDLE_THR:    set_idle_thr = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [30:0] g, input logic [16:0] r,
                             input logic [16:0] f, input logic [15:0] e,
                             input logic [31:0] t);
        write_reg(bbi_pkg::REG_GRAVITY, {1'b0, g});
        write_reg(bbi_pkg::REG_RESTITUTION, {15'd0, r});
        write_reg(bbi_pkg::REG_FRICTION, {15'd0, f});
        write_reg(bbi_pkg::REG_VEL_EPS, {16'd0, e});
        write_reg(bbi_pkg::REG_IDLE_THR, t);
    endtask

    // block until every queued item is taken and every result is back
    task automatic wait_drained();
        while (!(cmds_taken == cmds_queued && predicted_reports.size() == 0))
            @(negedge aclk);
    endtask

    initial begin
        int ph;
        int sent;
        int n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        set_gravity = bbi_pkg::DEF_GRAVITY;
        set_rest = bbi_pkg::DEF_RESTITUTION;
        set_fric = bbi_pkg::DEF_FRICTION;
        set_eps = bbi_pkg::DEF_VEL_EPS;
        set_idle_thr = bbi_pkg::DEF_IDLE_THR;
        for (n = 0; n < 3; n++) begin
            body_pos[n] = '0;
            body_vel[n] = '0;
        end
        moved_ms = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // resting body straight out of reset, idle threshold edges
        queue_step(32'd0, 16'd1000);
        queue_step(32'd6001, 16'd1000);
        queue_step(32'd6000, 16'd0);
        // extremes, wrapping sums
        queue_load(32'd100, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        queue_step(32'd200, 16'hFFFF);
        queue_load(32'd300, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        queue_step(32'd400, 16'hFFFF);
        queue_step(32'd500, 16'hFFFF);
        // on the ground with no velocity: rests even with x and y off center
        queue_load(32'd1000, 5 * ONE_PX, -7 * ONE_PX, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_step(32'd7001, 16'd500);
        // lands on exactly zero height
        queue_load(32'd8000, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, -32'sd64896);
        queue_step(32'd8010, 16'd1);
        queue_step(32'd8020, 16'd1000);
        // velocity cutoff right at epsilon, zero dt leaves the body unmoved
        queue_load(32'd9000, 32'd0, 32'd0, 100 * ONE_PX, 32'd66, -32'sd65, 32'd0);
        queue_step(32'd9010, 16'd0);
        queue_step(32'd20000, 16'd0);
        // idle across the ms counter wrap
        queue_load(32'hFFFF_FF00, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_step(32'h0000_0010, 16'd100);
        queue_step(32'h0000_2000, 16'd100);
        // hard bounce with sideways motion
        queue_load(32'h20, 32'd0, 32'd0, 10 * ONE_PX, 1000 * ONE_PX, -1000 * ONE_PX,
                   -300 * ONE_PX);
        queue_step(32'h30, 16'd16384);
        queue_step(32'h40, 16'd16384);
        queue_step(32'h50, 16'd16384);
        // starts below ground
        queue_load(32'h100, 32'd0, 32'd0, -5 * ONE_PX, 32'd0, 32'd0, 32'd0);
        queue_step(32'h110, 16'd2000);
        queue_step(32'h120, 16'd2000);
        sim_ms = 32'h1000;

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            unique case (ph)
                1: configure(31'd0, bbi_pkg::QONE, 17'd0, 16'd0, 32'd0);
                2: configure(31'h7FFF_FFFF, 17'd0, bbi_pkg::QONE, 16'hFFFF, 32'hFFFF_FFFF);
                3: configure(bbi_pkg::DEF_GRAVITY, 17'h1FFFF, 17'h1FFFF,
                             bbi_pkg::DEF_VEL_EPS, 32'd1000);
                4: configure(31'($urandom_range(0, 200000000)),
                             17'($urandom_range(0, 65536)),
                             17'($urandom_range(0, 65536)),
                             16'($urandom_range(0, 2000)),
                             $urandom_range(0, 5000));
                5: configure(bbi_pkg::DEF_GRAVITY, 17'd0, bbi_pkg::QONE,
                             bbi_pkg::DEF_VEL_EPS, 32'd300);
                default: ;
            endcase
            if (ph < 2) begin
                send_idle_pct = 16;
                recv_idle_pct = 77;
            end else if (ph < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 15) begin
                    queue_cmd(random_cmd());
                    sent++;
                end else begin
                    n = $urandom_range(5, 40);
                    queue_drop(n);
                    sent += n + 1;
                end
                // on one pass in ten on average, the sender holds off until the block has drained
                if ($urandom_range(9) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && predicted_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bbi_pkg.sv
sv/bbi_cfg.sv
sv/bbi_mul.sv
sv/bbi_ctrl.sv
sv/bouncing_body_integrator_core.sv
dv/bouncing_body_integrator_core_tb.sv
